// ----- hw/rtl/frame_builder_twos_sum_macros.svh -----
// ----------------------------------------------------------------------------
// frame builder assertion macros
// concurrent assertion wrappers clocked on clk, used by frame_builder_twos_sum
// ----------------------------------------------------------------------------
`ifndef FRAME_BUILDER_TWOS_SUM_MACROS_SVH
`define FRAME_BUILDER_TWOS_SUM_MACROS_SVH

// checked only while out of reset
`define FBTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FBTS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/fbts_pkg.sv -----
// ----------------------------------------------------------------------------
// fbts_pkg
// constants and header byte lookup for the byte frame builder
// ----------------------------------------------------------------------------
`default_nettype none

package fbts_pkg;

	localparam int MAX_PAYLOAD = 31;
	localparam int LEN_W       = 5;
	localparam int HDR_BYTES   = 16;
	localparam int IDX_W       = $clog2(HDR_BYTES + 1);

	localparam logic [7:0] START_BYTE = 8'hAA;
	localparam logic [7:0] LEN_BASE   = 8'h11;

	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	// header byte positions, every other position is zero
	localparam logic [IDX_W-1:0] POS_START   = IDX_W'(0);
	localparam logic [IDX_W-1:0] POS_LEN     = IDX_W'(1);
	localparam logic [IDX_W-1:0] POS_DESC_HI = IDX_W'(2);
	localparam logic [IDX_W-1:0] POS_DESC_LO = IDX_W'(3);
	localparam logic [IDX_W-1:0] POS_TYPE_HI = IDX_W'(12);
	localparam logic [IDX_W-1:0] POS_TYPE_LO = IDX_W'(13);

	function automatic logic [7:0] hdr_byte(
		input logic [IDX_W-1:0] idx,
		input logic [15:0]      desc,
		input logic [15:0]      mtype,
		input logic [LEN_W-1:0] len
	);
		logic [7:0] b;
		case (idx)
			POS_START:   b = START_BYTE;
			POS_LEN:     b = LEN_BASE + 8'(len);
			POS_DESC_HI: b = desc[15:8];
			POS_DESC_LO: b = desc[7:0];
			POS_TYPE_HI: b = mtype[15:8];
			POS_TYPE_LO: b = mtype[7:0];
			default:     b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/frame_builder_twos_sum.sv -----
// ----------------------------------------------------------------------------
// frame_builder_twos_sum
// builds header, payload and two's complement checksum bytes of a link frame
// ----------------------------------------------------------------------------
// A start word emits the 16-byte header, followed by the checksum when the
// payload length is zero. A payload word emits its data byte, so payload
// streams at one word per cycle unless byte_ready stalls the output; the
// word that carries the last payload byte also emits the checksum after it.
// The rate is set by the single byte-wide output register: one frame byte
// leaves per cycle while byte_ready is high. A payload word that arrives
// with no frame open is consumed and emits nothing. The next word is taken
// in the cycle in which the current one emits its last byte.
`default_nettype none

`include "frame_builder_twos_sum_macros.svh"

module frame_builder_twos_sum
	import fbts_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire logic             operation,
	input  wire logic [15:0]      descriptor,
	input  wire logic [15:0]      message_type,
	input  wire logic [LEN_W-1:0] payload_length,
	input  wire logic [7:0]       data_byte,
	output logic                  byte_valid,
	input  wire logic             byte_ready,
	output logic [7:0]            frame_byte,
	output logic                  end_of_frame,
	output logic                  end_of_run
);

	// current word
	logic             cur_valid_q;
	logic             cur_op_q;
	logic [15:0]      cur_desc_q;
	logic [15:0]      cur_type_q;
	logic [LEN_W-1:0] cur_len_q;
	logic [7:0]       cur_data_q;
	logic [IDX_W-1:0] idx_q;

	// frame state
	logic             in_frame_q;
	logic [LEN_W-1:0] remaining_q;
	logic [7:0]       sum_q;

	// output register
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_eof_q;
	logic             out_eor_q;

	logic             out_free;
	logic             step;
	logic             drop;
	logic [7:0]       emit_byte;
	logic             emit_eof;
	logic             emit_eor;
	logic [7:0]       checksum;
	logic [LEN_W-1:0] len_sat;
	logic             accept;

	assign checksum = ~sum_q + 8'd1;
	assign out_free = !out_valid_q || byte_ready;
	assign step     = cur_valid_q && (drop || out_free);
	assign item_ready = !cur_valid_q || (step && emit_eor);
	assign accept   = item_valid && item_ready;

	assign len_sat = (int'(payload_length) > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD)
		: payload_length;

	always_comb begin
		emit_byte = 8'h00;
		emit_eof  = 1'b0;
		emit_eor  = 1'b0;
		drop      = 1'b0;
		if (cur_op_q == OP_START) begin
			if (idx_q == IDX_W'(HDR_BYTES)) begin
				emit_byte = checksum;
				emit_eof  = 1'b1;
				emit_eor  = 1'b1;
			end else begin
				emit_byte = hdr_byte(idx_q, cur_desc_q, cur_type_q, cur_len_q);
				emit_eor  = (idx_q == IDX_W'(HDR_BYTES - 1)) && (cur_len_q != '0);
			end
		end else if (idx_q == '0) begin
			if (!in_frame_q) begin
				// no open frame, word is discarded
				drop     = 1'b1;
				emit_eor = 1'b1;
			end else begin
				emit_byte = cur_data_q;
				emit_eor  = (remaining_q != LEN_W'(1));
			end
		end else begin
			emit_byte = checksum;
			emit_eof  = 1'b1;
			emit_eor  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			in_frame_q  <= 1'b0;
			remaining_q <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (step) begin
				if (emit_eor) begin
					cur_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end

			if (step && !drop) begin
				if (emit_eof) begin
					sum_q       <= '0;
					in_frame_q  <= 1'b0;
					remaining_q <= '0;
				end else if (cur_op_q == OP_START && idx_q == '0) begin
					// first header byte restarts the sum and arms the payload count
					sum_q       <= emit_byte;
					in_frame_q  <= (cur_len_q != '0);
					remaining_q <= cur_len_q;
				end else begin
					sum_q <= sum_q + emit_byte;
					if (cur_op_q == OP_DATA) begin
						remaining_q <= remaining_q - LEN_W'(1);
					end
				end
			end

			if (out_free) begin
				out_valid_q <= step && !drop;
			end
		end
	end

	// word and byte payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_op_q   <= operation;
			cur_desc_q <= descriptor;
			cur_type_q <= message_type;
			cur_len_q  <= len_sat;
			cur_data_q <= data_byte;
		end
		if (out_free && step && !drop) begin
			out_byte_q <= emit_byte;
			out_eof_q  <= emit_eof;
			out_eor_q  <= emit_eor;
		end
	end

	assign byte_valid   = out_valid_q;
	assign frame_byte   = out_byte_q;
	assign end_of_frame = out_eof_q;
	assign end_of_run   = out_eor_q;

	`FBTS_ASSERT(a_eof_ends_run, (out_valid_q && out_eof_q) |-> out_eor_q, "checksum not last byte of run")
	`FBTS_ASSERT(a_idx_range, cur_valid_q |-> (idx_q <= IDX_W'(HDR_BYTES)), "byte index out of range")
	`FBTS_ASSERT_ALWAYS(a_idle_count, (!in_frame_q) |-> (remaining_q == '0), "count left while idle")
	`FBTS_ASSERT(a_accept_loads, accept |=> cur_valid_q, "accepted word not held")

endmodule

`default_nettype wire
